### rtl/core/gsa_pkg.sv
// Shared types, codes and a helper function of the generational slot allocator.
package gsa_pkg;

	localparam int SLOT_BITS       = 5;
	localparam int SLOTS_PER_CHUNK = 32;

	// Request codes.
	localparam logic [1:0] REQ_SPAWN = 2'd0;
	localparam logic [1:0] REQ_KILL  = 2'd1;
	localparam logic [1:0] REQ_CHECK = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
	localparam logic [1:0] STAT_INVALID   = 2'd2;

	// Generation written into every slot of a newly opened chunk.
	localparam logic [31:0] GEN_FRESH = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [1:0]  layout_sel;
		logic [7:0]  entity_index;
		logic [31:0] entity_gen;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_index;
		logic [31:0] out_gen;
		logic        is_valid;
	} rsp_t;

	typedef logic [2:0] cfg_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_GEN,
		S_SWEEP
	} state_t;

	typedef enum logic [2:0] {
		OP_BAD,
		OP_EXHAUST,
		OP_SPAWN_HIT,
		OP_SPAWN_OPEN,
		OP_KILL,
		OP_CHECK
	} op_t;

	// Position of the lowest set bit; an empty mask gives 31.
	function automatic logic [SLOT_BITS-1:0] lowest_set32(input logic [31:0] m);
		logic [SLOT_BITS-1:0] idx;
		idx = SLOT_BITS'(SLOTS_PER_CHUNK - 1);
		for (int i = SLOTS_PER_CHUNK - 1; i >= 0; i--) begin
			if (m[i]) begin
				idx = SLOT_BITS'(i);
			end
		end
		return idx;
	endfunction

endpackage

### rtl/core/gsa_chan_if.sv
// Valid/ready channel interface that carries one payload of type T.
interface gsa_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/gsa_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module gsa_ram #(
	parameter int AW = 5,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read enable.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/generational_slot_allocator.sv
// Top level of the generational slot allocator: handle spawn, kill and check per layout.
// A check, kill, refused request or chunk-opening spawn loads its result from the execute
// state; a spawn into an already open chunk loads it from the generation state, as the slot's
// generation is read only after the free mask has chosen the slot. Requests are taken one
// at a time, only when idle; a chunk-opening spawn then sweeps every slot of the new chunk.
// Reset clears the open-chunk counts and free-chunk bits and sets the active layout count to 4;
// the RAMs are not cleared, since only chunks that have been opened (and so written) are used.
module generational_slot_allocator #(
	parameter int NUM_LAYOUTS = 4,
	parameter int MAX_CHUNKS  = 8
) (
	input  logic clk,
	input  logic arst_n,
	gsa_chan_if.sink   req,
	gsa_chan_if.source rsp,
	gsa_chan_if.sink   cfg
);
	import gsa_pkg::*;

	// Layout and chunk field widths; a single layout or chunk still takes one address bit.
	localparam int LW   = (NUM_LAYOUTS > 1) ? $clog2(NUM_LAYOUTS) : 1;
	localparam int CW   = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int OW   = $clog2(MAX_CHUNKS + 1);
	localparam int CMPW = (OW > 3) ? OW : 3;
	localparam int MAW  = LW + CW;
	localparam int GAW  = MAW + SLOT_BITS;

	// Configuration and per-layout bookkeeping, all in flops.
	logic [2:0]            active_layouts_q;
	logic [OW-1:0]         chunks_open_q [NUM_LAYOUTS];
	logic [MAX_CHUNKS-1:0] has_free_q    [NUM_LAYOUTS];

	state_t state_q, state_d;

	// Request fields held while the request is worked on.
	op_t                  op_s1;
	logic [LW-1:0]        lay_s1;
	logic [CW-1:0]        chunk_s1;
	logic [SLOT_BITS-1:0] slot_s1;
	logic [31:0]          gen_s1;
	logic [SLOT_BITS-1:0] sweep_q;

	// Result register that parts the request side from the result side.
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Decode of the incoming request.
	logic                  accept;
	logic                  layout_ok;
	logic [LW-1:0]         lay_in;
	logic [OW-1:0]         open_in;
	logic [MAX_CHUNKS-1:0] free_in;
	logic [CW-1:0]         hit_chunk;
	logic                  idx_ok;
	op_t                   acc_op;
	logic [CW-1:0]         acc_chunk;

	// RAM ports.
	logic                 mask_we;
	logic [31:0]          mask_wdata;
	logic [31:0]          mask_rd;
	logic                 gen_we;
	logic [GAW-1:0]       gen_waddr;
	logic [31:0]          gen_wdata;
	logic                 gen_re;
	logic [GAW-1:0]       gen_raddr;
	logic [31:0]          gen_rd;

	// Control strobes from the sequencer.
	logic                 out_free;
	logic                 rsp_load;
	rsp_t                 rsp_d;
	logic                 open_inc;
	logic                 free_set;
	logic                 free_clr;
	logic                 take_slot;
	logic                 sweep_step;
	logic [SLOT_BITS-1:0] found_slot;
	logic [31:0]          taken_mask;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// The layout must be below both the configured count and the built-in count.
	assign layout_ok = ({1'b0, req.data.layout_sel} < active_layouts_q) &&
	                   (32'(req.data.layout_sel) < 32'(NUM_LAYOUTS));
	assign lay_in    = LW'(req.data.layout_sel);
	assign open_in   = chunks_open_q[lay_in];
	assign free_in   = has_free_q[lay_in];
	assign idx_ok    = CMPW'(req.data.entity_index[7:SLOT_BITS]) < CMPW'(open_in);

	// Lowest chunk of the layout that still has a free slot.
	always_comb begin
		hit_chunk = '0;
		for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
			if (free_in[i]) begin
				hit_chunk = CW'(i);
			end
		end
	end

	// Classify the request up front, so the RAM reads can start in the accept cycle.
	always_comb begin
		acc_op    = OP_BAD;
		acc_chunk = CW'(req.data.entity_index[7:SLOT_BITS]);
		if (layout_ok) begin
			case (req.data.req_type)
				REQ_SPAWN: begin
					if (|free_in) begin
						acc_op    = OP_SPAWN_HIT;
						acc_chunk = hit_chunk;
					end else if (open_in == OW'(MAX_CHUNKS)) begin
						acc_op = OP_EXHAUST;
					end else begin
						acc_op    = OP_SPAWN_OPEN;
						acc_chunk = CW'(open_in);
					end
				end
				REQ_KILL: begin
					acc_op = idx_ok ? OP_KILL : OP_BAD;
				end
				REQ_CHECK: begin
					acc_op = idx_ok ? OP_CHECK : OP_BAD;
				end
				default: begin
					acc_op = OP_BAD;
				end
			endcase
		end
	end

	assign found_slot = lowest_set32(mask_rd);
	assign taken_mask = mask_rd & ~(32'd1 << found_slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: one request at a time, read in the accept cycle, modify and write back after.
	always_comb begin
		state_d    = state_q;
		mask_we    = 1'b0;
		mask_wdata = taken_mask;
		gen_we     = 1'b0;
		gen_waddr  = {lay_s1, chunk_s1, slot_s1};
		gen_wdata  = gen_rd + 32'd1;
		gen_re     = 1'b0;
		gen_raddr  = {lay_in, acc_chunk, req.data.entity_index[SLOT_BITS-1:0]};
		rsp_load   = 1'b0;
		rsp_d      = '0;
		open_inc   = 1'b0;
		free_set   = 1'b0;
		free_clr   = 1'b0;
		take_slot  = 1'b0;
		sweep_step = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					gen_re  = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_s1)
					OP_SPAWN_HIT: begin
						// Take the lowest free slot now and fetch its generation.
						mask_we   = 1'b1;
						free_clr  = (taken_mask == '0);
						take_slot = 1'b1;
						gen_re    = 1'b1;
						gen_raddr = {lay_s1, chunk_s1, found_slot};
						state_d   = S_GEN;
					end
					OP_SPAWN_OPEN: begin
						if (out_free) begin
							// A new chunk has every slot free; slot zero is taken at once.
							mask_we          = 1'b1;
							mask_wdata       = ~32'd1;
							open_inc         = 1'b1;
							free_set         = 1'b1;
							rsp_load         = 1'b1;
							rsp_d.status     = STAT_OK;
							rsp_d.out_index  = 8'({chunk_s1, {SLOT_BITS{1'b0}}});
							rsp_d.out_gen    = GEN_FRESH;
							state_d          = S_SWEEP;
						end
					end
					OP_KILL: begin
						if (out_free) begin
							// Free the slot and bump its generation, even if it was free.
							mask_we      = 1'b1;
							mask_wdata   = mask_rd | (32'd1 << slot_s1);
							gen_we       = 1'b1;
							free_set     = 1'b1;
							rsp_load     = 1'b1;
							rsp_d.status = STAT_OK;
							state_d      = S_IDLE;
						end
					end
					OP_CHECK: begin
						if (out_free) begin
							rsp_load       = 1'b1;
							rsp_d.status   = STAT_OK;
							rsp_d.is_valid = (gen_rd == gen_s1) && !mask_rd[slot_s1];
							state_d        = S_IDLE;
						end
					end
					OP_EXHAUST: begin
						if (out_free) begin
							rsp_load     = 1'b1;
							rsp_d.status = STAT_EXHAUSTED;
							state_d      = S_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							rsp_load     = 1'b1;
							rsp_d.status = STAT_INVALID;
							state_d      = S_IDLE;
						end
					end
				endcase
			end
			S_GEN: begin
				if (out_free) begin
					rsp_load        = 1'b1;
					rsp_d.status    = STAT_OK;
					rsp_d.out_index = 8'({chunk_s1, slot_s1});
					rsp_d.out_gen   = gen_rd;
					state_d         = S_IDLE;
				end
			end
			S_SWEEP: begin
				// Write the fresh generation into every slot of the chunk just opened.
				gen_we     = 1'b1;
				gen_waddr  = {lay_s1, chunk_s1, sweep_q};
				gen_wdata  = GEN_FRESH;
				sweep_step = 1'b1;
				if (sweep_q == SLOT_BITS'(SLOTS_PER_CHUNK - 1)) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Request fields, captured on acceptance; a spawn into an open chunk then takes the slot found.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= acc_op;
			lay_s1   <= lay_in;
			chunk_s1 <= acc_chunk;
			slot_s1  <= req.data.entity_index[SLOT_BITS-1:0];
			gen_s1   <= req.data.entity_gen;
		end else if (take_slot) begin
			slot_s1 <= found_slot;
		end
	end

	// Sweep counter wraps back to zero at the end of each pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (sweep_step) begin
			sweep_q <= sweep_q + SLOT_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_layouts_q <= 3'd4;
		end else if (cfg.valid) begin
			active_layouts_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LAYOUTS; i++) begin
				chunks_open_q[i] <= '0;
				has_free_q[i]    <= '0;
			end
		end else begin
			if (open_inc) begin
				chunks_open_q[lay_s1] <= chunks_open_q[lay_s1] + OW'(1);
			end
			if (free_set) begin
				has_free_q[lay_s1][chunk_s1] <= 1'b1;
			end else if (free_clr) begin
				has_free_q[lay_s1][chunk_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// Free-slot masks, one row per layout and chunk.
	gsa_ram #(
		.AW (MAW),
		.DW (32)
	) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr ({lay_s1, chunk_s1}),
		.wdata (mask_wdata),
		.re    (accept),
		.raddr ({lay_in, acc_chunk}),
		.rdata (mask_rd)
	);

	// Slot generations, one entry per layout, chunk and slot.
	gsa_ram #(
		.AW (GAW),
		.DW (32)
	) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (gen_raddr),
		.rdata (gen_rd)
	);

`ifndef SYNTHESIS
	// A result is never loaded over one that has not been taken.
	a_no_rsp_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> out_free)
		else $error("result register overwritten while still pending");

	// An accepted request is always worked on in the next cycle.
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("accepted request did not enter execution");

	// A chunk marked as having a free slot must really have one.
	a_hit_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_s1 == OP_SPAWN_HIT) |-> (mask_rd != '0))
		else $error("free-chunk bit set for a full chunk");

	// A chunk is opened only while the layout is below its chunk limit.
	a_open_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		open_inc |-> (chunks_open_q[lay_s1] < OW'(MAX_CHUNKS)))
		else $error("chunk opened beyond the limit");

	// The generation RAM is never read and written in the same cycle.
	a_gen_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(gen_we && gen_re))
		else $error("generation RAM read and written together");
`endif

endmodule
